[rtl/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 6;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] word;
        logic                     last;
        logic [OCC_W-1:0]         occupancy;
    } resp_t;

endpackage

[rtl/dq_ram.sv]
// Slot storage: one write port, one read port, registered read data.
module dq_ram #(
    parameter int DEPTH  = dq_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = dq_pkg::DATA_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/double_ended_queue.sv]
// Double-ended queue top level: ring-buffer control around the slot memory.
// Push and pop: one request per cycle while not busy, result in the cycle after acceptance.
// List: one result per held word, one per cycle; busy stays high while the remaining words are read.
// Empty list, full push, empty pop: single result in the cycle after acceptance.
// Reset empties the queue; slot contents are not cleared. The receiver cannot stall.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dq_pkg::req_t  req,
    output logic          busy,
    output logic          done,
    output dq_pkg::resp_t resp
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = dq_pkg::DATA_W;
    localparam int OCC_W  = dq_pkg::OCC_W;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    list_off_reg, list_off_next;
    logic                done_reg, done_next;
    dq_pkg::status_t     status_reg, status_next;
    logic                last_reg, last_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic                word_sel_reg, word_sel_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic                re;
    logic [IDX_W-1:0]    raddr;
    logic [DATA_W-1:0]   rdata;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (IDX_W+1)'(DEPTH))
        begin
            s = s - (IDX_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign busy   = (state_reg == S_LIST);
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        list_off_next = list_off_reg;
        done_next     = 1'b0;
        status_next   = dq_pkg::ST_OK;
        last_next     = 1'b1;
        occ_next      = count_reg;
        word_sel_next = 1'b0;
        we            = 1'b0;
        waddr         = '0;
        re            = 1'b0;
        raddr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = dq_pkg::ST_FULL;
                            end
                            else
                            begin
                                we = 1'b1;
                                if (req.op == dq_pkg::OP_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                                   : front_reg - 1'b1;
                                    waddr      = front_next;
                                end
                                else
                                begin
                                    waddr = wrap_add(front_reg, IDX_W'(count_reg));
                                end
                                count_next = count_reg + 1'b1;
                                occ_next   = count_next;
                            end
                        end
                        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK:
                        begin
                            done_next = 1'b1;
                            if (empty)
                            begin
                                status_next = dq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                re            = 1'b1;
                                word_sel_next = 1'b1;
                                if (req.op == dq_pkg::OP_POP_FRONT)
                                begin
                                    raddr      = front_reg;
                                    front_next = wrap_add(front_reg, IDX_W'(1));
                                end
                                else
                                begin
                                    raddr = wrap_add(front_reg, IDX_W'(count_reg - 1'b1));
                                end
                                count_next = count_reg - 1'b1;
                                occ_next   = count_next;
                            end
                        end
                        dq_pkg::OP_LIST:
                        begin
                            done_next = 1'b1;
                            if (empty)
                            begin
                                status_next = dq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                re            = 1'b1;
                                raddr         = front_reg;
                                word_sel_next = 1'b1;
                                last_next     = (count_reg == CNT_W'(1));
                                list_off_next = CNT_W'(1);
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = S_LIST;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                re            = 1'b1;
                raddr         = wrap_add(front_reg, IDX_W'(list_off_reg));
                done_next     = 1'b1;
                word_sel_next = 1'b1;
                last_next     = (list_off_reg == count_reg - 1'b1);
                list_off_next = list_off_reg + 1'b1;
                if (last_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            list_off_reg <= '0;
            done_reg     <= 1'b0;
            status_reg   <= dq_pkg::ST_OK;
            last_reg     <= 1'b0;
            occ_reg      <= '0;
            word_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            list_off_reg <= list_off_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
            occ_reg      <= occ_next;
            word_sel_reg <= word_sel_next;
        end
    end

    dq_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (req.value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign done           = done_reg;
    assign resp.status    = status_reg;
    assign resp.word      = word_sel_reg ? rdata : '0;
    assign resp.last      = last_reg;
    assign resp.occupancy = OCC_W'(occ_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("held count exceeds depth");

    a_list_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (count_reg > CNT_W'(1)))
        else $error("list sequencing with fewer than two words");

    a_list_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (list_off_reg < count_reg))
        else $error("list offset out of range");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !resp.last) |=> done)
        else $error("result burst ended without last");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && resp.last) |-> !busy)
        else $error("busy while final result shown");
`endif

endmodule
